// ===== src/gflc_pkg.sv =====
package gflc_pkg;

    // Default table depth
    localparam int DEF_TABLE_DEPTH = 1024;

    // Fixed-point constants (Q16.16) and integer phase and divisor constants
    localparam logic signed [31:0] BASE_LEVEL        = 32'sd1092267;
    localparam logic signed [32:0] SUM_LIMIT         = 33'sd262144000;
    localparam logic signed [31:0] DECLINE_MIN_FORCE = 32'sd524288;
    localparam int                 START_WINDOW      = 10;
    localparam int                 LEAD_START        = 5;
    localparam int                 PEAK_HALF         = 2;
    localparam int                 DECL_DIVISOR      = 24;

    // Run modes
    localparam logic [2:0] MODE_LEARN = 3'd1;
    localparam logic [2:0] MODE_OPEN  = 3'd2;
    localparam logic [2:0] MODE_EXT   = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] REG_DERIV_GAIN   = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd2;
    localparam logic [2:0] REG_TABLE_LENGTH = 3'd3;
    localparam logic [2:0] REG_RUN_MODE     = 3'd4;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ERR,
        ST_PID0,
        ST_PID1,
        ST_PID2,
        ST_PID3,
        ST_IDX,
        ST_START,
        ST_COPY,
        ST_FIX_RD,
        ST_FIX_WR,
        ST_FF_RD,
        ST_FF_GET,
        ST_SEL,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_POST,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        BR_RAMP,
        BR_PEAK,
        BR_DECL
    } t_branch;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/gflc_ram.sv =====
module gflc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/gait_force_learning_controller_core.sv =====
// Gait force controller with a learned per-phase feedforward table.
// Input channel: i_valid / o_stall carries one force sample per transaction
// (set point, measured force, phase, profile phases, peak target, external
// correction). Output channel: o_valid / i_stall carries one drive_force per
// input transaction, in order.
// Configuration: APB-style port, gains at 0x0/0x4/0x8, table length at 0xC,
// run mode at 0x10; write only while the block is idle.
// One sample is in work at a time. When a cycle start in learning mode
// copies the command table into the feedforward table, the copy loop sets
// the worst case, together with the one-bit-per-cycle serial divider in the
// ramp and decline profile segments.
// Reset: clears the control state and configuration registers and then
// sweeps both tables to zero, one entry per cycle, while o_stall stays high.
// A result waits in the output register while i_stall is high; the next
// sample is taken meanwhile and holds in its final step until that
// register frees up.
module gait_force_learning_controller_core
    import gflc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_desired_force,
    input  logic signed [31:0] i_measured_force,
    input  logic [9:0]         i_phase_index,
    input  logic [9:0]         i_start_phase,
    input  logic [9:0]         i_rise_phase,
    input  logic [9:0]         i_fall_phase,
    input  logic signed [31:0] i_peak_target,
    input  logic signed [31:0] i_external_correction,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_drive_force,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Configuration registers
    logic signed [31:0] r_prop_gain, r_deriv_gain, r_integ_gain;
    logic [10:0]        r_table_length;
    logic [2:0]         r_run_mode;

    // Sequencer and latched sample
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_cnt, n_clr_cnt;
    logic signed [31:0] r_des, r_meas, r_tgt, r_ext;
    logic [9:0]         r_phase, r_ts, r_tr, r_tf;
    logic [9:0]         r_idx, n_idx;

    // Controller state
    logic signed [31:0] r_err, n_err, r_diff, n_diff, r_prev, n_prev, r_sum, n_sum;
    logic signed [31:0] r_peak_acc, n_peak_acc, r_fall_acc, n_fall_acc;
    logic signed [31:0] r_peak_seen, n_peak_seen, r_early, n_early, r_late, n_late;
    logic               r_started, n_started;

    // Datapath
    logic signed [63:0] r_gprod, n_gprod;
    logic signed [49:0] r_pid_acc, n_pid_acc;
    logic signed [31:0] r_ff, n_ff, r_res, n_res;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_cp_v, n_cp_v;
    logic [AW-1:0]      r_cp_addr, n_cp_addr;
    logic signed [33:0] r_mul_a, n_mul_a;
    logic signed [14:0] r_mul_b, n_mul_b;
    logic signed [47:0] r_prod, n_prod;
    t_branch            r_branch, n_branch;
    logic [12:0]        r_div_d, n_div_d;
    logic [13:0]        r_div_rem, n_div_rem;
    logic [47:0]        r_div_q, n_div_q;
    logic               r_div_neg, n_div_neg;
    logic [5:0]         r_div_cnt, n_div_cnt;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out, n_out;

    // Memory ports
    logic               cmd_wr_en, ff_wr_en;
    logic [AW-1:0]      cmd_wr_addr, ff_wr_addr, cmd_rd_addr, ff_rd_addr;
    logic [31:0]        cmd_wr_data, ff_wr_data, cmd_rd_data, ff_rd_data;

    logic in_acc;
    logic cfg_wr;

    assign in_acc = i_valid && !o_stall;
    assign cfg_wr = psel && penable && pwrite && pready;

    gflc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_cmd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cmd_wr_en),
        .i_wr_addr (cmd_wr_addr),
        .i_wr_data (cmd_wr_data),
        .i_rd_addr (cmd_rd_addr),
        .o_rd_data (cmd_rd_data)
    );

    gflc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ff_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ff_wr_en),
        .i_wr_addr (ff_wr_addr),
        .i_wr_data (ff_wr_data),
        .i_rd_addr (ff_rd_addr),
        .o_rd_data (ff_rd_data)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= '0;
            r_deriv_gain   <= '0;
            r_integ_gain   <= '0;
            r_table_length <= '0;
            r_run_mode     <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_PROP_GAIN:    r_prop_gain    <= pwdata;
                REG_DERIV_GAIN:   r_deriv_gain   <= pwdata;
                REG_INTEG_GAIN:   r_integ_gain   <= pwdata;
                REG_TABLE_LENGTH: r_table_length <= pwdata[10:0];
                REG_RUN_MODE:     r_run_mode     <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        case (paddr[4:2])
            REG_PROP_GAIN:    prdata = r_prop_gain;
            REG_DERIV_GAIN:   prdata = r_deriv_gain;
            REG_INTEG_GAIN:   prdata = r_integ_gain;
            REG_TABLE_LENGTH: prdata = {21'd0, r_table_length};
            REG_RUN_MODE:     prdata = {29'd0, r_run_mode};
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_prev      <= '0;
            r_sum       <= '0;
            r_peak_acc  <= '0;
            r_fall_acc  <= '0;
            r_peak_seen <= '0;
            r_early     <= '0;
            r_late      <= '0;
            r_started   <= 1'b0;
            r_cp_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_prev      <= n_prev;
            r_sum       <= n_sum;
            r_peak_acc  <= n_peak_acc;
            r_fall_acc  <= n_fall_acc;
            r_peak_seen <= n_peak_seen;
            r_early     <= n_early;
            r_late      <= n_late;
            r_started   <= n_started;
            r_cp_v      <= n_cp_v;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_des   <= i_desired_force;
            r_meas  <= i_measured_force;
            r_phase <= i_phase_index;
            r_ts    <= i_start_phase;
            r_tr    <= i_rise_phase;
            r_tf    <= i_fall_phase;
            r_tgt   <= i_peak_target;
            r_ext   <= i_external_correction;
        end
        r_idx     <= n_idx;
        r_err     <= n_err;
        r_diff    <= n_diff;
        r_gprod   <= n_gprod;
        r_pid_acc <= n_pid_acc;
        r_ff      <= n_ff;
        r_res     <= n_res;
        r_cnt     <= n_cnt;
        r_cp_addr <= n_cp_addr;
        r_mul_a   <= n_mul_a;
        r_mul_b   <= n_mul_b;
        r_prod    <= n_prod;
        r_branch  <= n_branch;
        r_div_d   <= n_div_d;
        r_div_rem <= n_div_rem;
        r_div_q   <= n_div_q;
        r_div_neg <= n_div_neg;
        r_div_cnt <= n_div_cnt;
        r_out     <= n_out;
    end

    // Sequencer: next state, datapath and memory controls
    always_comb begin
        logic signed [32:0] wide33;
        logic signed [33:0] wide34;
        logic signed [31:0] err_s, pid_s, ffpid_s, fin;
        logic signed [14:0] s_v, ts_v, tr_v, tf_v, d_v;
        logic [CW-1:0]      n_lim;
        logic               start_now;
        logic [14:0]        trial;
        logic [14:0]        shifted;
        logic signed [48:0] q_s;

        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_idx       = r_idx;
        n_err       = r_err;
        n_diff      = r_diff;
        n_prev      = r_prev;
        n_sum       = r_sum;
        n_peak_acc  = r_peak_acc;
        n_fall_acc  = r_fall_acc;
        n_peak_seen = r_peak_seen;
        n_early     = r_early;
        n_late      = r_late;
        n_started   = r_started;
        n_gprod     = r_gprod;
        n_pid_acc   = r_pid_acc;
        n_ff        = r_ff;
        n_res       = r_res;
        n_cnt       = r_cnt;
        n_cp_v      = r_cp_v;
        n_cp_addr   = r_cp_addr;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_prod      = r_prod;
        n_branch    = r_branch;
        n_div_d     = r_div_d;
        n_div_rem   = r_div_rem;
        n_div_q     = r_div_q;
        n_div_neg   = r_div_neg;
        n_div_cnt   = r_div_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        cmd_wr_en   = 1'b0;
        cmd_wr_addr = AW'(r_idx);
        cmd_wr_data = r_res;
        cmd_rd_addr = r_cnt[AW-1:0];
        ff_wr_en    = 1'b0;
        ff_wr_addr  = r_cp_addr;
        ff_wr_data  = cmd_rd_data;
        ff_rd_addr  = AW'(r_idx);
        o_stall     = (r_state != ST_IDLE);

        pid_s   = sat32(64'(r_pid_acc));
        ffpid_s = sat32(64'(r_ff) + 64'(pid_s));
        s_v     = 15'($unsigned(r_phase));
        ts_v    = 15'($unsigned(r_ts));
        tr_v    = 15'($unsigned(r_tr));
        tf_v    = 15'($unsigned(r_tf));
        d_v     = tr_v - ts_v + 15'(LEAD_START - PEAK_HALF);
        n_lim   = (13'(r_table_length) < 13'(TABLE_DEPTH)) ? CW'(r_table_length)
                                                             : CW'(TABLE_DEPTH);
        start_now = (r_phase < 10'(START_WINDOW)) && !r_started;
        err_s   = '0;
        wide33  = '0;
        wide34  = '0;
        shifted = {r_div_rem, r_div_q[47]};
        trial   = shifted - {2'b00, r_div_d};
        q_s     = r_div_neg ? (-$signed({1'b0, r_div_q}) - 49'(r_div_rem != '0))
                            : $signed({1'b0, r_div_q});
        fin     = '0;

        case (r_state)
            // Sweep both tables to zero after reset
            ST_CLEAR: begin
                cmd_wr_en   = 1'b1;
                cmd_wr_addr = r_clr_cnt;
                cmd_wr_data = '0;
                ff_wr_en    = 1'b1;
                ff_wr_addr  = r_clr_cnt;
                ff_wr_data  = '0;
                n_clr_cnt   = r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_idx   = i_phase_index;
                    n_state = ST_ERR;
                end
            end
            // Error, error change and clamped error sum
            ST_ERR: begin
                err_s  = sat32(64'(r_meas) - 64'(r_des));
                n_err  = err_s;
                n_diff = sat32(64'(err_s) - 64'(r_prev));
                n_prev = err_s;
                wide33 = 33'(r_sum) + 33'(err_s);
                if (wide33 > SUM_LIMIT) begin
                    wide33 = SUM_LIMIT;
                end
                if (wide33 < -SUM_LIMIT) begin
                    wide33 = -SUM_LIMIT;
                end
                n_sum   = wide33[31:0];
                n_state = ST_PID0;
            end
            // Gain products, one multiplier per cycle, each accumulated from r_gprod in the next state
            ST_PID0: begin
                n_gprod = 64'(r_prop_gain) * 64'(r_err);
                n_state = ST_PID1;
            end
            ST_PID1: begin
                n_pid_acc = -50'(r_gprod >>> 16);
                n_gprod   = 64'(r_deriv_gain) * 64'(r_diff);
                n_state   = ST_PID2;
            end
            ST_PID2: begin
                n_pid_acc = r_pid_acc - 50'(r_gprod >>> 16);
                n_gprod   = 64'(r_integ_gain) * 64'(r_sum);
                n_state   = ST_PID3;
            end
            ST_PID3: begin
                n_pid_acc = r_pid_acc - 50'(r_gprod >>> 16);
                n_state   = ST_IDX;
            end
            // Reduce the phase to a table index
            ST_IDX: begin
                if (13'(r_idx) >= 13'(TABLE_DEPTH)) begin
                    n_idx = r_idx - 10'(TABLE_DEPTH);
                end else begin
                    n_state = ST_START;
                end
            end
            // Cycle start bookkeeping
            ST_START: begin
                n_state = ST_FF_RD;
                if (start_now) begin
                    n_sum       = '0;
                    wide34      = 34'(r_peak_acc) + 34'(r_tgt) - 34'(r_peak_seen);
                    n_peak_acc  = sat32(64'(wide34));
                    wide33      = (33'(r_early) + 33'(r_late)) >>> 1;
                    n_fall_acc  = sat32(64'(r_fall_acc) + 64'(wide33));
                    n_peak_seen = '0;
                    n_early     = '0;
                    n_late      = '0;
                    n_started   = 1'b1;
                    if (r_run_mode == MODE_LEARN) begin
                        n_cnt   = '0;
                        n_cp_v  = 1'b0;
                        n_state = ST_COPY;
                    end
                end
                if (r_phase >= 10'(START_WINDOW)) begin
                    n_started = 1'b0;
                end
            end
            // Copy command table into feedforward table, one entry per cycle
            ST_COPY: begin
                ff_wr_en  = r_cp_v;
                n_cp_v    = (r_cnt < n_lim);
                n_cp_addr = r_cnt[AW-1:0];
                if (r_cnt < n_lim) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_cp_v) begin
                    n_state = ST_FIX_RD;
                end
            end
            // Entry 0 takes entry 1
            ST_FIX_RD: begin
                ff_rd_addr = AW'(1);
                n_state    = ST_FIX_WR;
            end
            ST_FIX_WR: begin
                ff_wr_en   = 1'b1;
                ff_wr_addr = '0;
                ff_wr_data = ff_rd_data;
                n_state    = ST_FF_RD;
            end
            ST_FF_RD: begin
                n_state = ST_FF_GET;
            end
            ST_FF_GET: begin
                n_ff = ff_rd_data;
                n_state = (r_run_mode == MODE_LEARN) ? ST_SEL : ST_FINAL;
            end
            // Pick the profile segment
            ST_SEL: begin
                n_state = ST_FINAL;
                if (s_v + 15'(LEAD_START) <= ts_v) begin
                    n_res = ffpid_s;
                    if (ffpid_s > BASE_LEVEL) begin
                        n_res = BASE_LEVEL;
                    end
                    if (ffpid_s < 0) begin
                        n_res = '0;
                    end
                end else if (s_v + 15'(PEAK_HALF) <= tr_v) begin
                    if (d_v > 0) begin
                        n_mul_a  = 34'(r_tgt) + 34'(r_peak_acc);
                        n_mul_b  = 15'((s_v - ts_v + 15'(LEAD_START)) * 15'sd5);
                        n_div_d  = 13'(d_v * 15'sd6);
                        n_branch = BR_RAMP;
                        n_state  = ST_MUL;
                    end else begin
                        n_res = BASE_LEVEL;
                    end
                end else if (s_v <= tr_v + 15'(PEAK_HALF)) begin
                    n_mul_a  = 34'(r_tgt) + 34'(r_peak_acc);
                    n_mul_b  = tr_v + 15'(PEAK_HALF) - s_v;
                    n_branch = BR_PEAK;
                    n_state  = ST_MUL;
                end else if (r_des > DECLINE_MIN_FORCE) begin
                    n_mul_a  = -(34'(r_tgt) + 34'(r_fall_acc));
                    n_mul_b  = 15'((s_v - tr_v - 15'(PEAK_HALF)) * 15'sd5);
                    n_div_d  = 13'(DECL_DIVISOR);
                    n_branch = BR_DECL;
                    n_state  = ST_MUL;
                end else begin
                    n_res = BASE_LEVEL;
                end
            end
            ST_MUL: begin
                n_prod  = 48'(r_mul_a) * 48'(r_mul_b);
                n_state = (r_branch == BR_PEAK) ? ST_POST : ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                n_div_neg = r_prod[47];
                n_div_q   = r_prod[47] ? 48'(-r_prod) : 48'(r_prod);
                n_div_rem = '0;
                n_div_cnt = '0;
                n_state   = ST_DIV;
            end
            // Restoring divide, one quotient bit per cycle
            ST_DIV: begin
                if (!trial[14]) begin
                    n_div_rem = trial[13:0];
                    n_div_q   = {r_div_q[46:0], 1'b1};
                end else begin
                    n_div_rem = shifted[13:0];
                    n_div_q   = {r_div_q[46:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == 6'd47) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                case (r_branch)
                    BR_PEAK: begin
                        n_res = sat32(64'(BASE_LEVEL) + 64'(r_prod >>> 3));
                        if (n_res < 0) begin
                            n_res = '0;
                        end
                    end
                    BR_RAMP: begin
                        n_res = sat32(64'(BASE_LEVEL) + 64'(q_s));
                        if (n_res < 0) begin
                            n_res = '0;
                        end
                    end
                    default: begin
                        n_res = sat32(64'(q_s));
                        if (n_res < -BASE_LEVEL) begin
                            n_res = -BASE_LEVEL;
                        end
                    end
                endcase
                n_state = ST_FINAL;
            end
            // Form the result, update learning state, hand off
            ST_FINAL: begin
                if (!(r_out_valid && i_stall)) begin
                    case (r_run_mode)
                        MODE_LEARN: fin = r_res;
                        MODE_OPEN:  fin = r_ff;
                        MODE_EXT:   fin = sat32(64'(r_ff) + 64'(r_ext));
                        default:    fin = ffpid_s;
                    endcase
                    if (r_run_mode == MODE_LEARN) begin
                        cmd_wr_en = 1'b1;
                        if (r_meas > r_peak_seen) begin
                            n_peak_seen = r_meas;
                        end
                        if (s_v + 15'sd2 == tf_v) begin
                            n_early = r_err;
                        end
                        if (s_v == tf_v + 15'sd1) begin
                            n_late = r_err;
                        end
                    end
                    if (r_started) begin
                        fin = r_ff;
                    end
                    n_out       = fin;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_drive_force = r_out;

endmodule

// ===== verif/gait_force_learning_controller_core_tb.sv =====
module gait_force_learning_controller_core_tb;
    import gflc_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct {
        logic signed [31:0] des;
        logic signed [31:0] meas;
        logic [9:0]         ph;
        logic [9:0]         ts;
        logic [9:0]         tr;
        logic [9:0]         tf;
        logic signed [31:0] tgt;
        logic signed [31:0] ext;
    } sample_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_desired_force = '0;
    logic signed [31:0] i_measured_force = '0;
    logic [9:0]         i_phase_index = '0;
    logic [9:0]         i_start_phase = '0;
    logic [9:0]         i_rise_phase = '0;
    logic [9:0]         i_fall_phase = '0;
    logic signed [31:0] i_peak_target = '0;
    logic signed [31:0] i_external_correction = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [31:0] o_drive_force;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    gait_force_learning_controller_core dut (.*);

    always #4 i_clk = ~i_clk;

    // Controller settings and state mirrored from the block
    logic signed [31:0] kp, kd, ki;
    logic [10:0]        tab_len;
    logic [2:0]         mode;
    logic signed [31:0] prev_err, err_sum, peak_acc, fall_acc, peak_max, early_err, late_err;
    logic               in_cycle;
    logic signed [31:0] cmd_tab [DEPTH];
    logic signed [31:0] ff_tab [DEPTH];

    sample_t            sample_q[$];
    logic signed [31:0] drive_q[$];
    sample_t            cur;
    int                 errors = 0;
    bit                 calm = 1'b0;
    int                 hold_req = 0;
    int                 hold_cnt = 0;
    int                 quiet = 0;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
        return floor_div(longint'(a) * longint'(b), 65536);
    endfunction

    function automatic logic signed [31:0] floor_at(logic signed [31:0] v, logic signed [31:0] lo);
        return (v < lo) ? lo : v;
    endfunction

    // Advance the controller by one force sample and return the drive force
    task automatic predict_drive(input sample_t x, output logic signed [31:0] r);
        logic signed [31:0] err, diff, pid, ff;
        longint s, ts, tr, tf, acc, pk, dv, ramp;
        int n;
        s = longint'(x.ph);
        ts = longint'(x.ts);
        tr = longint'(x.tr);
        tf = longint'(x.tf);
        err = clip32(longint'(x.meas) - longint'(x.des));
        diff = clip32(longint'(err) - longint'(prev_err));
        prev_err = err;
        acc = longint'(err_sum) + longint'(err);
        if (acc > 262144000) acc = 262144000;
        if (acc < -262144000) acc = -262144000;
        err_sum = acc[31:0];
        pid = clip32(-qmul(kp, err) - qmul(kd, diff) - qmul(ki, err_sum));

        // Cycle start: refresh feedforward table and corrections
        if (s < START_WINDOW && !in_cycle) begin
            if (mode == MODE_LEARN) begin
                n = (tab_len < DEPTH) ? tab_len : DEPTH;
                for (int a = 0; a < n; a++) ff_tab[a] = cmd_tab[a];
                ff_tab[0] = ff_tab[1];
            end
            err_sum = '0;
            peak_acc = clip32(longint'(peak_acc) + longint'(x.tgt) - longint'(peak_max));
            fall_acc = clip32(longint'(fall_acc)
                + floor_div(longint'(early_err) + longint'(late_err), 2));
            peak_max = '0;
            early_err = '0;
            late_err = '0;
            in_cycle = 1'b1;
        end
        if (s >= START_WINDOW) in_cycle = 1'b0;

        ff = ff_tab[s % DEPTH];
        r = clip32(longint'(ff) + longint'(pid));

        if (mode == MODE_LEARN) begin
            pk = longint'(x.tgt) + longint'(peak_acc);
            if (s <= ts - LEAD_START) begin
                if (r > BASE_LEVEL) r = BASE_LEVEL;
                r = floor_at(r, 0);
            end else if (s <= tr - PEAK_HALF) begin
                dv = tr - ts + LEAD_START - PEAK_HALF;
                ramp = 0;
                if (dv > 0) ramp = floor_div(pk * 5 * (s - ts + LEAD_START), 6 * dv);
                r = floor_at(clip32(longint'(BASE_LEVEL) + ramp), 0);
            end else if (s <= tr + PEAK_HALF) begin
                r = floor_at(clip32(longint'(BASE_LEVEL)
                    + floor_div(pk * (4 - (s - tr + PEAK_HALF)), 8)), 0);
            end else if (x.des > DECLINE_MIN_FORCE) begin
                pk = longint'(x.tgt) + longint'(fall_acc);
                r = floor_at(clip32(floor_div(-pk * 5 * (s - tr - PEAK_HALF), DECL_DIVISOR)),
                    -BASE_LEVEL);
            end else begin
                r = BASE_LEVEL;
            end
            if (x.meas > peak_max) peak_max = x.meas;
            if (s == tf - 2) early_err = err;
            if (s == tf + 1) late_err = err;
            cmd_tab[s % DEPTH] = r;
        end else if (mode == MODE_OPEN) begin
            r = ff;
        end else if (mode == MODE_EXT) begin
            r = clip32(longint'(ff) + longint'(x.ext));
        end
        if (in_cycle) r = ff;
    endtask

    // Drive force samples; predict on each accepted transaction
    always @(posedge i_clk) begin
        logic signed [31:0] exp_val;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_drive(cur, exp_val);
                drive_q.push_back(exp_val);
            end
            if (!i_valid || !o_stall) begin
                if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
                    cur = sample_q.pop_front();
                    i_valid <= 1'b1;
                    i_desired_force <= cur.des;
                    i_measured_force <= cur.meas;
                    i_phase_index <= cur.ph;
                    i_start_phase <= cur.ts;
                    i_rise_phase <= cur.tr;
                    i_fall_phase <= cur.tf;
                    i_peak_target <= cur.tgt;
                    i_external_correction <= cur.ext;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Take results, stall at random, and check each transaction
    always @(posedge i_clk) begin
        if (o_valid && !i_stall && i_rst_n) begin
            if (drive_q.size() == 0) begin
                $error("drive_force: unexpected result %0d", o_drive_force);
                errors++;
            end else begin
                if (o_drive_force !== drive_q[0]) begin
                    $error("drive_force: expected %0d, got %0d", drive_q[0], o_drive_force);
                    errors++;
                end
                void'(drive_q.pop_front());
            end
        end
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 38);
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PROP_GAIN:    kp = val;
            REG_DERIV_GAIN:   kd = val;
            REG_INTEG_GAIN:   ki = val;
            REG_TABLE_LENGTH: tab_len = val[10:0];
            REG_RUN_MODE:     mode = val[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (sample_q.size() > 0 || i_valid || drive_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_gains(input logic [31:0] p, input logic [31:0] d, input logic [31:0] i);
        reg_write(REG_PROP_GAIN, p);
        reg_write(REG_DERIV_GAIN, d);
        reg_write(REG_INTEG_GAIN, i);
    endtask

    task automatic add_sample(input logic [31:0] des, input logic [31:0] meas,
                              input logic [9:0] ph, input logic [9:0] ts,
                              input logic [9:0] tr, input logic [9:0] tf,
                              input logic [31:0] tgt, input logic [31:0] ext);
        sample_t x;
        x.des = des; x.meas = meas; x.ph = ph; x.ts = ts;
        x.tr = tr; x.tf = tf; x.tgt = tgt; x.ext = ext;
        sample_q.push_back(x);
    endtask

    function automatic logic [31:0] force_val();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1500000, 0) - 200000;
            default: return $urandom_range(1000000, 400000);
        endcase
    endfunction

    function automatic logic [31:0] gain_val();
        case ($urandom_range(3))
            0: return $urandom;
            1: return '0;
            default: return $urandom_range(40000) - 20000;
        endcase
    endfunction

    // One gait cycle of phase-ordered samples with random content
    task automatic add_gait_cycle(input int last_ph);
        logic [9:0] ts, tr, tf;
        logic [31:0] tgt;
        ts = $urandom_range(20);
        tr = ($urandom_range(4) == 0) ? $urandom_range(3) : ts + $urandom_range(12);
        tf = tr + $urandom_range(10, 2);
        tgt = ($urandom_range(5) == 0) ? $urandom : $urandom_range(2000000, 0) - 300000;
        for (int s = 0; s <= last_ph; s++)
            add_sample(($urandom_range(2) == 0) ? $urandom_range(524288) : force_val(),
                       force_val(), s, ts, tr, tf, tgt, $urandom);
    endtask

    initial begin
        kp = '0; kd = '0; ki = '0; tab_len = '0; mode = '0;
        prev_err = '0; err_sum = '0; peak_acc = '0; fall_acc = '0;
        peak_max = '0; early_err = '0; late_err = '0; in_cycle = 1'b0;
        for (int a = 0; a < DEPTH; a++) begin
            cmd_tab[a] = '0;
            ff_tab[a] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme fields in closed loop, external and open-loop modes
        set_gains(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000, 10'd1023, 10'd0, 10'd0, 10'd0, 0, 0);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF, 10'd0, 10'd1023, 10'd1023, 10'd1023,
                   32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF, 10'd9, 10'h155, 10'h2AA, 10'h155,
                   32'h8000_0000, 32'h7FFF_FFFF);
        add_sample(0, 32'h7FFF_FFFF, 10'd10, 10'h2AA, 10'h155, 10'h2AA, 0, 0);
        add_sample(0, 32'h7FFF_FFFF, 10'd11, 0, 0, 0, 0, 0);
        wait_idle();
        reg_write(REG_RUN_MODE, MODE_EXT);
        add_sample(0, 0, 10'd512, 0, 0, 0, 0, 32'h7FFF_FFFF);
        add_sample(0, 0, 10'd513, 0, 0, 0, 0, 32'h8000_0000);
        wait_idle();
        reg_write(REG_RUN_MODE, MODE_OPEN);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF, 10'd300, 0, 0, 0, 0, 0);
        wait_idle();

        // Directed learning: flat, ramp, peak, decline, hold, wrap
        set_gains(32'h0000_8000, 32'h0000_1000, 32'h0000_0100);
        reg_write(REG_TABLE_LENGTH, 11'd1024);
        reg_write(REG_RUN_MODE, MODE_LEARN);
        for (int s = 0; s < 14; s++)
            add_sample((s & 1) ? 32'h000A_0000 : 32'h0004_0000, 32'h0006_0000 + s,
                       s, 10'd6, 10'd9, 10'd8, 32'h0014_0000, 0);
        add_sample(32'h000A_0000, 32'h0001_0000, 10'd3, 10'd2, 10'd0, 10'd5, 32'h0010_0000, 0);
        add_sample(32'h000A_0000, 32'h0001_0000, 10'd12, 10'd2, 10'd0, 10'd5, 0, 0);
        add_sample(32'h000A_0000, 32'h0001_0000, 10'd2, 10'd0, 10'd0, 10'd1, 0, 0);
        wait_idle();
        reg_write(REG_TABLE_LENGTH, 11'd2047);
        add_gait_cycle(14);
        wait_idle();

        // Random: mostly small tables, shaped gait cycles in learning mode
        for (int ph = 0; ph < 10; ph++) begin
            set_gains(gain_val(), gain_val(), gain_val());
            reg_write(REG_TABLE_LENGTH, (ph == 4) ? 11'd1024 : $urandom_range(64));
            reg_write(REG_RUN_MODE, MODE_LEARN);
            calm = (ph == 2);
            if (ph == 5) hold_req = 400;
            repeat (2) add_gait_cycle($urandom_range(40, 14));
            for (int k = 0; k < 4; k++)
                add_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
            wait_idle();
            calm = 1'b0;
            reg_write(REG_RUN_MODE, $urandom_range(7));
            for (int k = 0; k < 14; k++)
                add_sample(force_val(), force_val(),
                           ($urandom_range(3) == 0) ? $urandom : $urandom_range(30),
                           $urandom, $urandom, $urandom, $urandom, $urandom);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) begin
            if (drive_q.size() > 0) break;
            @(posedge i_clk);
        end
        if (errors == 0 && drive_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
